/* src/metronome_click_mixer_macros.svh */
// assertion helpers shared by the click mixer modules
`ifndef METRONOME_CLICK_MIXER_MACROS_SVH
`define METRONOME_CLICK_MIXER_MACROS_SVH

`ifndef SYNTHESIS
`define MCM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MCM_ASSERT(name, clk, rst_n, prop, msg)
`define MCM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/mcm_pkg.sv */
package mcm_pkg;

  localparam int unsigned MaxClickLength = 2048;
  localparam int unsigned SineTableDepth = 1024;
  localparam int unsigned SampleBits     = 24;

  localparam int unsigned EnvSize = 2048;
  localparam int unsigned EnvAw   = 11;

  localparam int unsigned PosW    = 40;
  localparam int unsigned VolW    = 17;
  localparam int unsigned SrW     = 19;
  localparam int unsigned TempoW  = 18;
  localparam int unsigned BpbW    = 7;
  localparam int unsigned BeatW   = 42;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 19;

  localparam logic [CfgIdxW-1:0] CfgEnabled = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVolume  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRate    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTempo   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBpb     = 3'd4;

  localparam int unsigned MinRate  = 8000;
  localparam int unsigned MinTempo = 5120;

  // shared divider: dividend, divisor and iteration counter widths
  localparam int unsigned DivNw = 58;
  localparam int unsigned DivDw = 33;
  localparam int unsigned DivCw = 6;

  typedef struct packed {
    logic             start;
    logic [DivCw-1:0] iters;
    logic [DivNw-1:0] dividend;
    logic [DivDw-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam longint Q30One = 64'sd1073741824;

  typedef logic [31:0] env_rom_t [EnvSize];

  function automatic longint mul_q30(longint a, longint b);
    logic   neg;
    longint ma;
    longint mb;
    longint r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    r   = (ma * mb + (longint'(1) <<< 29)) >>> 30;
    return neg ? -r : r;
  endfunction

  // sin(pi/2 * u), u in q30 over [0, 1]
  function automatic longint quarter_sine(longint u);
    longint u2;
    longint acc;
    u2  = mul_q30(u, u);
    acc = -64'sd3864;
    acc = 64'sd172272 + mul_q30(u2, acc);
    acc = -64'sd5026995 + mul_q30(u2, acc);
    acc = 64'sd85569306 + mul_q30(u2, acc);
    acc = -64'sd693598668 + mul_q30(u2, acc);
    acc = 64'sd1686629713 + mul_q30(u2, acc);
    acc = mul_q30(u, acc);
    if (acc < 0) acc = 0;
    if (acc > Q30One) acc = Q30One;
    return acc;
  endfunction

  // full cycle table entry, depth given as log2
  function automatic logic [31:0] sine_entry(int unsigned idx, int unsigned lg);
    longint v;
    longint quad;
    longint u;
    longint s;
    v    = longint'(idx) * 4;
    quad = v >>> lg;
    u    = (v & ((longint'(1) <<< lg) - 1)) <<< (30 - lg);
    if (quad[0]) u = Q30One - u;
    s = quarter_sine(u);
    if (quad >= 2) s = -s;
    return s[31:0];
  endfunction

  function automatic env_rom_t build_env();
    env_rom_t e;
    e[0] = Q30One[31:0];
    for (int i = 1; i < EnvSize; i++) begin
      e[i] = 32'(mul_q30(longint'(e[i-1]), 64'sd1072693760));
    end
    return e;
  endfunction

endpackage

/* src/mcm_if.sv */
interface mcm_in_if #(
  parameter int unsigned SAMPLE_BITS = mcm_pkg::SampleBits
) ();
  logic                          valid;
  logic                          ready;
  logic [mcm_pkg::PosW-1:0]      sample_position;
  logic                          transport_playing;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (
    output valid, sample_position, transport_playing, left_in, right_in,
    input  ready
  );
  modport sink (
    input  valid, sample_position, transport_playing, left_in, right_in,
    output ready
  );
endinterface

interface mcm_out_if #(
  parameter int unsigned SAMPLE_BITS = mcm_pkg::SampleBits
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          click_active;
  logic                          accent_beat;

  modport source (
    output valid, left_out, right_out, click_active, accent_beat,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, click_active, accent_beat,
    output ready
  );
endinterface

/* src/mcm_div.sv */
`include "metronome_click_mixer_macros.svh"

module mcm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mcm_pkg::div_req_t         req_i,
  output mcm_pkg::div_stat_t        stat_o,
  output logic [mcm_pkg::DivNw-1:0] quo_o,
  output logic [mcm_pkg::DivDw-1:0] rem_o
);
  import mcm_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [DivCw-1:0] cnt_q;
  logic [DivNw-1:0] num_q;
  logic [DivDw-1:0] rem_q;
  logic [DivDw-1:0] den_q;
  logic [DivDw:0]   trial;
  logic             fits;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_q, num_q[DivNw-1]} - {1'b0, den_q};
  assign fits  = !trial[DivDw];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend is left aligned so only its meaningful bits are walked
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend << (DivCw'(DivNw) - req_i.iters);
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[DivNw-2:0], fits};
      rem_q <= fits ? trial[DivDw-1:0] : {rem_q[DivDw-2:0], num_q[DivNw-1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;
  assign rem_o       = rem_q;

  `MCM_ASSERT_IMP(a_no_restart, clk_i, rst_ni, req_i.start, !busy_q, "divider restarted while busy")
  `MCM_ASSERT_IMP(a_rem_below, clk_i, rst_ni, done_q, rem_q < den_q, "remainder not below divisor")
  `MCM_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without a run")

endmodule

/* src/mcm_rom.sv */
module mcm_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = mcm_pkg::SineTableDepth
) (
  input  logic                                 clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]  sine_addr_i,
  input  logic [mcm_pkg::EnvAw-1:0]            env_addr_i,
  output logic signed [31:0]                   sine_o,
  output logic [31:0]                          env_o
);
  import mcm_pkg::*;

  localparam int unsigned SineAw = $clog2(SINE_TABLE_DEPTH);
  localparam env_rom_t EnvRom = build_env();

  logic signed [31:0] sine_tab [SINE_TABLE_DEPTH];
  logic signed [31:0] sine_q;
  logic [31:0]        env_q;

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sine
    localparam logic [31:0] Entry = sine_entry(gi, SineAw);
    assign sine_tab[gi] = Entry;
  end

  always_ff @(posedge clk_i) begin
    sine_q <= sine_tab[sine_addr_i];
    env_q  <= EnvRom[env_addr_i];
  end

  assign sine_o = sine_q;
  assign env_o  = env_q;

endmodule

/* src/metronome_click_mixer.sv */
// metronome click mixer
// frame_i carries one stereo word (two samples, transport position, playing
// flag); frame_o returns the same frame with the click added and two flags.
// cfg_we_i / cfg_idx_i / cfg_data_i write the registers: 0 enable, 1 volume,
// 2 sample rate, 3 tempo, 4 beats per bar; write them only while idle.
// a word is worked on alone; frame_i.ready is low until its result sits
// in the output register. a frame to which no click applies goes straight
// to the mix step; one outside the click window or repeating the last
// clicked downbeat takes only the beat and offset divisions, and a clicked
// frame takes all five divisions of the shared restoring divider, which
// produces one quotient bit per cycle (beat, offset, accent, sine phase,
// envelope index). the next word can enter in the cycle after the result
// is registered.
// the output register lets a new word enter while a result waits, and a
// result stalled by frame_o.ready holds the sequencer at its last step.
// reset restores the register defaults, drops the last clicked beat and
// empties the output register.
`include "metronome_click_mixer_macros.svh"

module metronome_click_mixer #(
  parameter int unsigned MAX_CLICK_LENGTH = mcm_pkg::MaxClickLength,
  parameter int unsigned SINE_TABLE_DEPTH = mcm_pkg::SineTableDepth,
  parameter int unsigned SAMPLE_BITS      = mcm_pkg::SampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcm_pkg::CfgDataW-1:0] cfg_data_i,
  mcm_in_if.sink                       frame_i,
  mcm_out_if.source                    frame_o
);
  import mcm_pkg::*;

  localparam int unsigned SineAw   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned LenW     = $clog2(MAX_CLICK_LENGTH + 1);
  localparam int unsigned ScaleSh  = 63 - SAMPLE_BITS;
  localparam int unsigned NBits    = 21;
  localparam int unsigned NIters   = 33;
  localparam int unsigned PhIters  = 11 + LenW + SineAw;
  localparam int unsigned EiIters  = 17 + LenW;
  localparam int unsigned AvW      = 33;
  localparam int unsigned SumW     = SAMPLE_BITS + 2;

  localparam logic signed [SumW-1:0] SatHi = SumW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_BEAT  = 4'd2;
  localparam logic [3:0] ST_N     = 4'd3;
  localparam logic [3:0] ST_LEN   = 4'd4;
  localparam logic [3:0] ST_MOD   = 4'd5;
  localparam logic [3:0] ST_PH    = 4'd6;
  localparam logic [3:0] ST_EI    = 4'd7;
  localparam logic [3:0] ST_ROM   = 4'd8;
  localparam logic [3:0] ST_MAG   = 4'd9;
  localparam logic [3:0] ST_SCALE = 4'd10;
  localparam logic [3:0] ST_MIX   = 4'd11;

  // configuration
  logic              enabled_q;
  logic [VolW-1:0]   volume_q;
  logic [SrW-1:0]    sr_q;
  logic [TempoW-1:0] tempo_q;
  logic [BpbW-1:0]   bpb_q;
  logic              last_valid_q;
  logic [BeatW-1:0]  last_beat_q;

  logic [3:0] state_q;
  logic [3:0] state_d;

  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [DivNw-1:0] div_quo;
  logic [DivDw-1:0] div_rem;

  logic [DivNw-1:0]              num_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic [BeatW-1:0]              beat_q;
  logic [NBits-1:0]              n_q;
  logic                          accent_q;
  logic                          active_q;
  logic [SineAw-1:0]             ph_q;
  logic [EnvAw-1:0]              ei_q;
  logic [30:0]                   mag_q;
  logic                          neg_q;
  logic [AvW-1:0]                av_q;
  logic signed [SAMPLE_BITS:0]   click_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;
  logic                          out_active_q;
  logic                          out_accent_q;

  logic                          accept;
  logic [DivNw-1:0]              pos_x_tempo;
  logic [DivDw-1:0]              den;
  logic                          go;
  logic [31:0]                   n_cost;
  logic [31:0]                   len_room;
  logic                          in_click;
  logic                          repeat_hit;
  logic [BpbW-1:0]               bpb_eff;
  logic [VolW-1:0]               vol_sat;
  logic                          accent_now;
  logic [10:0]                   freq;
  logic [LenW-1:0]               n_short;
  logic [PhIters-1:0]            ph_num;
  logic [EiIters-1:0]            ei_num;
  logic [EnvAw-1:0]              ei_clip;
  logic signed [31:0]            rom_sine;
  logic [31:0]                   rom_env;
  logic [30:0]                   sine_mag;
  logic [61:0]                   se_prod;
  logic [63:0]                   sc_prod;
  logic [SAMPLE_BITS-1:0]        scaled;
  logic [15:0]                   amp;
  logic signed [SumW-1:0]        sum_l;
  logic signed [SumW-1:0]        sum_r;
  logic signed [SAMPLE_BITS-1:0] sat_l;
  logic signed [SAMPLE_BITS-1:0] sat_r;
  logic                          mix_go;

  assign accept      = frame_i.valid && frame_i.ready;
  assign pos_x_tempo = frame_i.sample_position * tempo_q;
  // samples per beat times tempo: sr * 15360
  assign den         = (DivDw'(sr_q) << 14) - (DivDw'(sr_q) << 10);
  assign go          = enabled_q && frame_i.transport_playing
                       && (sr_q >= SrW'(MinRate)) && (tempo_q >= TempoW'(MinTempo))
                       && (den >= DivDw'({tempo_q, 3'b000}));

  // n lies in the click window when n < MAX_CLICK_LENGTH and (n + 1) * 1000 <= sr * 18
  assign n_cost     = (32'(n_q) + 32'd1) * 32'd1000;
  assign len_room   = 32'(sr_q) * 32'd18;
  assign in_click   = (n_q < NBits'(MAX_CLICK_LENGTH)) && (n_cost <= len_room);
  assign repeat_hit = (n_q == '0) && last_valid_q && (last_beat_q == beat_q);
  assign bpb_eff    = (bpb_q == '0) ? BpbW'(1) : bpb_q;
  assign vol_sat    = (volume_q > VolW'(65536)) ? VolW'(65536) : volume_q;

  assign accent_now = (div_rem == '0);
  assign freq       = accent_now ? 11'd1800 : 11'd1000;
  assign n_short    = n_q[LenW-1:0];
  // table depth is a power of two, so the phase wrap is a bit select
  assign ph_num     = (PhIters'(freq) * PhIters'(n_short)) << SineAw;
  assign ei_num     = EiIters'(17'd92160) * EiIters'(n_short);
  assign ei_clip    = (div_quo[EiIters-1:0] > EiIters'(EnvSize - 1))
                      ? EnvAw'(EnvSize - 1) : div_quo[EnvAw-1:0];

  assign amp      = accent_q ? 16'd36045 : 16'd22938;
  assign sine_mag = 31'(rom_sine[31] ? -rom_sine : rom_sine);
  assign se_prod  = sine_mag * rom_env[30:0];
  assign sc_prod  = 64'(mag_q) * 64'(av_q) + (64'd1 << (ScaleSh - 1));
  assign scaled   = SAMPLE_BITS'(sc_prod >> ScaleSh);

  assign sum_l  = SumW'(left_q) + SumW'(click_q);
  assign sum_r  = SumW'(right_q) + SumW'(click_q);
  assign sat_l  = (sum_l > SatHi) ? SatHi[SAMPLE_BITS-1:0]
                : (sum_l < SatLo) ? SatLo[SAMPLE_BITS-1:0] : sum_l[SAMPLE_BITS-1:0];
  assign sat_r  = (sum_r > SatHi) ? SatHi[SAMPLE_BITS-1:0]
                : (sum_r < SatLo) ? SatLo[SAMPLE_BITS-1:0] : sum_r[SAMPLE_BITS-1:0];
  assign mix_go = !out_valid_q || frame_o.ready;

  // sequencer: steps hand the divisions in turn to the shared divider, then ROM, magnitude, scale and mix steps follow
  always_comb begin
    state_d = state_q;
    div_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = go ? ST_MUL : ST_MIX;
      end
      ST_MUL: begin
        div_req.start    = 1'b1;
        div_req.iters    = DivCw'(DivNw);
        div_req.dividend = num_q;
        div_req.divisor  = den;
        state_d          = ST_BEAT;
      end
      ST_BEAT: begin
        if (div_stat.done) begin
          div_req.start    = 1'b1;
          div_req.iters    = DivCw'(NIters);
          div_req.dividend = DivNw'(div_rem);
          div_req.divisor  = DivDw'(tempo_q);
          state_d          = ST_N;
        end
      end
      ST_N: begin
        if (div_stat.done) state_d = ST_LEN;
      end
      ST_LEN: begin
        if (in_click && !repeat_hit) begin
          div_req.start    = 1'b1;
          div_req.iters    = DivCw'(BeatW);
          div_req.dividend = DivNw'(beat_q);
          div_req.divisor  = DivDw'(bpb_eff);
          state_d          = ST_MOD;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_MOD: begin
        if (div_stat.done) begin
          div_req.start    = 1'b1;
          div_req.iters    = DivCw'(PhIters);
          div_req.dividend = DivNw'(ph_num);
          div_req.divisor  = DivDw'(sr_q);
          state_d          = ST_PH;
        end
      end
      ST_PH: begin
        if (div_stat.done) begin
          div_req.start    = 1'b1;
          div_req.iters    = DivCw'(EiIters);
          div_req.dividend = DivNw'(ei_num);
          div_req.divisor  = DivDw'(sr_q);
          state_d          = ST_EI;
        end
      end
      ST_EI: begin
        if (div_stat.done) state_d = ST_ROM;
      end
      ST_ROM:   state_d = ST_MAG;
      ST_MAG:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_MIX;
      ST_MIX: begin
        if (mix_go) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enabled_q    <= 1'b0;
      volume_q     <= VolW'(52429);
      sr_q         <= SrW'(48000);
      tempo_q      <= TempoW'(30720);
      bpb_q        <= BpbW'(4);
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LEN && in_click && n_q == '0 && !repeat_hit) begin
        last_valid_q <= 1'b1;
      end
      if (frame_o.ready) out_valid_q <= 1'b0;
      if (state_q == ST_MIX && mix_go) out_valid_q <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgEnabled: begin
            enabled_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) last_valid_q <= 1'b0;
          end
          CfgVolume: volume_q <= cfg_data_i[VolW-1:0];
          CfgRate:   sr_q     <= cfg_data_i[SrW-1:0];
          CfgTempo:  tempo_q  <= cfg_data_i[TempoW-1:0];
          CfgBpb:    bpb_q    <= cfg_data_i[BpbW-1:0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q    <= pos_x_tempo;
      left_q   <= frame_i.left_in;
      right_q  <= frame_i.right_in;
      click_q  <= '0;
      active_q <= 1'b0;
      accent_q <= 1'b0;
    end
    if (state_q == ST_LEN && in_click && n_q == '0 && !repeat_hit) last_beat_q <= beat_q;
    if (div_stat.done) begin
      if (state_q == ST_BEAT) beat_q <= div_quo[BeatW-1:0];
      if (state_q == ST_N) n_q <= div_quo[NBits-1:0];
      if (state_q == ST_MOD) accent_q <= accent_now;
      if (state_q == ST_PH) ph_q <= div_quo[SineAw-1:0];
      if (state_q == ST_EI) ei_q <= ei_clip;
    end
    if (state_q == ST_MAG) begin
      mag_q <= 31'((se_prod + (62'd1 << 29)) >> 30);
      neg_q <= rom_sine[31];
      av_q  <= AvW'(amp) * AvW'(vol_sat);
    end
    if (state_q == ST_SCALE) begin
      click_q  <= neg_q ? -(SAMPLE_BITS+1)'(scaled) : (SAMPLE_BITS+1)'(scaled);
      active_q <= 1'b1;
    end
    if (state_q == ST_MIX && mix_go) begin
      out_left_q   <= sat_l;
      out_right_q  <= sat_r;
      out_active_q <= active_q;
      out_accent_q <= accent_q;
    end
  end

  mcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  mcm_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i       (clk_i),
    .sine_addr_i (ph_q),
    .env_addr_i  (ei_q),
    .sine_o      (rom_sine),
    .env_o       (rom_env)
  );

  assign frame_i.ready        = (state_q == ST_IDLE);
  assign frame_o.valid        = out_valid_q;
  assign frame_o.left_out     = out_left_q;
  assign frame_o.right_out    = out_right_q;
  assign frame_o.click_active = out_active_q;
  assign frame_o.accent_beat  = out_accent_q;

  `MCM_ASSERT_IMP(a_div_in_div_steps, clk_i, rst_ni, div_stat.busy,
    state_q == ST_BEAT || state_q == ST_N || state_q == ST_LEN || state_q == ST_MOD || state_q == ST_PH || state_q == ST_EI,
    "divider running outside a divide step")
  `MCM_ASSERT_IMP(a_accent_needs_click, clk_i, rst_ni, frame_o.valid && !frame_o.click_active,
    !frame_o.accent_beat, "accent flagged without a click")
  `MCM_ASSERT(a_disable_forgets, clk_i, rst_ni,
    cfg_we_i && cfg_idx_i == CfgEnabled && !cfg_data_i[0] |=> !last_valid_q,
    "last clicked beat kept after disable")

endmodule

/* sim/metronome_click_mixer_tb.sv */
module metronome_click_mixer_tb;
  import mcm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd5;

  typedef struct {
    logic [PosW-1:0]              pos;
    logic                         play;
    logic signed [SampleBits-1:0] left;
    logic signed [SampleBits-1:0] right;
  } frame_t;

  typedef struct {
    logic signed [SampleBits-1:0] left;
    logic signed [SampleBits-1:0] right;
    logic                         active;
    logic                         accent;
  } mix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  mcm_in_if  frame_in ();
  mcm_out_if frame_out ();

  metronome_click_mixer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_in),
    .frame_o    (frame_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  longint sine_tab [SineTableDepth];
  longint env_tab [EnvSize];
  longint unsigned en_r, vol_r, sr_r, tempo_r, bpb_r;
  bit              beat_seen;
  longint unsigned beat_last;

  frame_t pend_q[$];
  mix_t   mix_q[$];
  frame_t cur;
  bit     taken = 0;
  int     gap = 0;
  int     stall = 0;
  int     hold_cnt = 0;
  bit     hold_req = 0;
  bit     quiet = 0;
  int     errors = 0;
  int     n_frames = 0, n_clicks = 0, n_accents = 0;

  function automatic longint qmul(longint a, longint b);
    bit     neg;
    longint r;
    neg = (a < 0) != (b < 0);
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    r = (a * b + (longint'(1) << 29)) >>> 30;
    return neg ? -r : r;
  endfunction

  function automatic longint qsin(longint u);
    longint u2, acc;
    u2  = qmul(u, u);
    acc = -3864;
    acc = 172272 + qmul(u2, acc);
    acc = -5026995 + qmul(u2, acc);
    acc = 85569306 + qmul(u2, acc);
    acc = -693598668 + qmul(u2, acc);
    acc = 1686629713 + qmul(u2, acc);
    acc = qmul(u, acc);
    if (acc < 0) acc = 0;
    if (acc > Q30One) acc = Q30One;
    return acc;
  endfunction

  function automatic longint sat_sample(longint v);
    longint hi, lo;
    hi = (longint'(1) << (SampleBits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic mix_t mix_frame(frame_t f);
    mix_t r;
    longint unsigned den, num, beat, n, len, bpb, vol, freq, amp, ph, ei, mag;
    longint s, click;
    bit skip, neg;
    click = 0;
    r.active = 0;
    r.accent = 0;
    if (en_r != 0 && f.play && sr_r >= MinRate && tempo_r >= MinTempo &&
        sr_r * 15360 >= 8 * tempo_r) begin
      den  = sr_r * 15360;
      num  = longint'(f.pos) * tempo_r;
      beat = num / den;
      n    = (num % den) / tempo_r;
      len  = sr_r * 18 / 1000;
      if (len > MaxClickLength) len = MaxClickLength;
      skip = 0;
      if (n < len) begin
        if (n == 0) begin
          if (beat_seen && beat_last == beat) skip = 1;
          else begin
            beat_seen = 1;
            beat_last = beat;
          end
        end
        if (!skip) begin
          bpb = bpb_r != 0 ? bpb_r : 1;
          vol = vol_r > 65536 ? 65536 : vol_r;
          r.accent = (beat % bpb) == 0;
          freq = r.accent ? 1800 : 1000;
          amp  = r.accent ? 36045 : 22938;
          ph   = (freq * n * SineTableDepth / sr_r) % SineTableDepth;
          ei   = 92160 * n / sr_r;
          if (ei >= EnvSize) ei = EnvSize - 1;
          s    = qmul(sine_tab[ph], env_tab[ei]);
          neg  = s < 0;
          mag  = neg ? -s : s;
          mag  = (mag * amp * vol + (64'd1 << (62 - SampleBits))) >> (63 - SampleBits);
          click = neg ? -longint'(mag) : longint'(mag);
          r.active = 1;
        end
      end
    end
    r.left  = sat_sample(longint'(f.left) + click);
    r.right = sat_sample(longint'(f.right) + click);
    return r;
  endfunction

  // driver: accept at rising edge, drive at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && frame_in.valid && frame_in.ready) begin
      mix_q.push_back(mix_frame(cur));
      n_frames++;
      taken = 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      frame_in.valid <= 1'b0;
    end else if (frame_in.valid && !taken) begin
      // hold the word until it is taken
    end else begin
      taken = 0;
      if (gap > 0) begin
        gap--;
        frame_in.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(1, 14) - 1;
        frame_in.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        frame_in.valid             <= 1'b1;
        frame_in.sample_position   <= cur.pos;
        frame_in.transport_playing <= cur.play;
        frame_in.left_in           <= cur.left;
        frame_in.right_in          <= cur.right;
      end else begin
        frame_in.valid <= 1'b0;
      end
    end
  end

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      frame_out.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      frame_out.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 2000;
      frame_out.ready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      frame_out.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 14) - 1;
      frame_out.ready <= 1'b0;
    end else begin
      frame_out.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mix_t e;
    if (rst_ni && frame_out.valid && frame_out.ready) begin
      if (mix_q.size() == 0) begin
        $display("%0t: unexpected word l=%0d r=%0d", $time, frame_out.left_out,
                 frame_out.right_out);
        errors++;
      end else begin
        e = mix_q.pop_front();
        if (e.active) n_clicks++;
        if (e.accent) n_accents++;
        if (frame_out.left_out !== e.left) begin
          $display("%0t: left_out expected %0d actual %0d", $time, e.left,
                   frame_out.left_out);
          errors++;
        end
        if (frame_out.right_out !== e.right) begin
          $display("%0t: right_out expected %0d actual %0d", $time, e.right,
                   frame_out.right_out);
          errors++;
        end
        if (frame_out.click_active !== e.active) begin
          $display("%0t: click_active expected %0b actual %0b", $time, e.active,
                   frame_out.click_active);
          errors++;
        end
        if (frame_out.accent_beat !== e.accent) begin
          $display("%0t: accent_beat expected %0b actual %0b", $time, e.accent,
                   frame_out.accent_beat);
          errors++;
        end
      end
    end
  end

  task automatic put_reg(logic [CfgIdxW-1:0] idx, longint unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    case (idx)
      CfgEnabled: begin
        en_r = val & 1;
        if (en_r == 0) begin
          beat_seen = 0;
          beat_last = 0;
        end
      end
      CfgVolume: vol_r   = val & 64'h1FFFF;
      CfgRate:   sr_r    = val & 64'h7FFFF;
      CfgTempo:  tempo_r = val & 64'h3FFFF;
      CfgBpb:    bpb_r   = val & 64'h7F;
      default: ;
    endcase
  endtask

  task automatic set_all(longint unsigned en, longint unsigned vol, longint unsigned sr,
                         longint unsigned tempo, longint unsigned bpb);
    put_reg(CfgEnabled, en);
    put_reg(CfgVolume, vol);
    put_reg(CfgRate, sr);
    put_reg(CfgTempo, tempo);
    put_reg(CfgBpb, bpb);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || frame_in.valid || mix_q.size() != 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic add(longint unsigned pos, bit play, longint l, longint r);
    frame_t f;
    f.pos   = pos[PosW-1:0];
    f.play  = play;
    f.left  = l[SampleBits-1:0];
    f.right = r[SampleBits-1:0];
    pend_q.push_back(f);
  endtask

  function automatic longint rand_sample();
    case ($urandom_range(0, 9))
      0: return -8388608;
      1: return 8388607;
      default: return $signed(24'($urandom));
    endcase
  endfunction

  // first position of beat k under current registers
  function automatic longint unsigned beat_start(longint unsigned k);
    longint unsigned den;
    den = sr_r * 15360;
    return (k * den + tempo_r - 1) / tempo_r;
  endfunction

  task automatic random_items(int count);
    longint unsigned maxk, k, base, len, p;
    int run, sel;
    bit play;
    while (count > 0) begin
      sel  = $urandom_range(0, 99);
      play = $urandom_range(0, 19) != 0;
      if (tempo_r < 64 || sr_r == 0 || sel >= 88) begin
        p = {$urandom, $urandom};
        add(p, play, rand_sample(), rand_sample());
        count--;
      end else begin
        maxk = ((64'd1 << PosW) - 8192) * tempo_r / (sr_r * 15360);
        if (maxk == 0) maxk = 1;
        k = {$urandom, $urandom} % maxk;
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 200);
        base = beat_start(k);
        len  = sr_r * 18 / 1000;
        if (len > MaxClickLength) len = MaxClickLength;
        if (sel < 70) begin
          p   = ($urandom_range(0, 2) == 0) ? base : base + $urandom_range(0, len + 4);
          run = $urandom_range(1, 6);
          for (int i = 0; i < run && count > 0; i++) begin
            add(p, play, rand_sample(), rand_sample());
            count--;
            // sometimes replay the same frame to hit the repeated downbeat
            if ($urandom_range(0, 3) != 0) p++;
          end
        end else begin
          add(base + {$urandom, $urandom} % (sr_r * 15360 / tempo_r + 1), play,
              rand_sample(), rand_sample());
          count--;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SineTableDepth; i++) begin
      longint v, quad, u, s;
      v    = 4 * i;
      quad = v / SineTableDepth;
      u    = ((v % SineTableDepth) << 30) / SineTableDepth;
      if (quad[0]) u = Q30One - u;
      s = qsin(u);
      sine_tab[i] = quad >= 2 ? -s : s;
    end
    env_tab[0] = Q30One;
    for (int i = 1; i < EnvSize; i++) env_tab[i] = qmul(env_tab[i-1], 1072693760);
    en_r = 0; vol_r = 52429; sr_r = 48000; tempo_r = 30720; bpb_r = 4;
    beat_seen = 0; beat_last = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // default rate, tempo and beats per bar, full volume, clicks on: downbeat, its repeat, window edges, extremes
    set_all(1, 65536, 48000, 30720, 4);
    add(0, 1, 0, 0);
    add(0, 1, 100, -100);
    add(1, 1, 8388607, 8388607);
    add(3, 1, -8388608, -8388608);
    add(863, 1, 0, 0);
    add(864, 1, 5, 5);
    add(24000, 1, 8388600, -8388600);
    add(24010, 0, 1234, -1234);
    add(96000, 1, 0, 0);
    add(96000, 1, 0, 0);
    add(64'hFF_FFFF_FFFF, 1, -1, 1);
    add(48, 1, 8388607, -8388608);
    drain();
    set_all(1, 131071, 384000, 262143, 0);
    put_reg(CfgUnused, 19'h7FFFF);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    add(0, 1, 8388607, -8388608);
    add(5, 1, 0, 0);
    add(beat_start(1) + 2, 1, 0, 0);
    drain();
    set_all(1, 0, 8000, 5120, 64);
    add(0, 1, 77, 77);
    add(24000 * 64, 1, 0, 0);
    add(24000 * 3 + 10, 1, 0, 0);
    drain();
    set_all(1, 40000, 7999, 30720, 127);
    add(0, 1, 1, 1);
    drain();
    put_reg(CfgRate, 48000);
    put_reg(CfgTempo, 5119);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    add(0, 1, 2, 2);
    drain();
    put_reg(CfgTempo, 30720);
    put_reg(CfgEnabled, 0);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    add(0, 1, 3, 3);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 15) quiet = 1;
      case (ph)
        0: set_all(1, 52429, 8000, 5120, 1);
        1: set_all(1, 65536, 384000, 262143, 64);
        2: set_all(1, $urandom_range(65536, 131071), 48000, 30720, 0);
        default:
          set_all($urandom_range(0, 9) != 0, $urandom_range(0, 131071),
                  $urandom_range(0, 15) == 0 ? $urandom_range(0, 524287)
                                             : $urandom_range(8000, 384000),
                  $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(5120, 262143),
                  $urandom_range(0, 127));
      endcase
      if (ph == 5) hold_req = 1;
      random_items(112);
      drain();
    end

    $display("frames %0d, clicked %0d, accented %0d over 20 register settings",
             n_frames, n_clicks, n_accents);
    $display("covered register extremes, repeated downbeats, pass-through and stalls");
    if (errors == 0) begin
      $display("PASS metronome_click_mixer");
    end else begin
      $display("FAIL metronome_click_mixer");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL metronome_click_mixer");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/mcm_pkg.sv
src/mcm_if.sv
src/mcm_div.sv
src/mcm_rom.sv
src/metronome_click_mixer.sv
sim/metronome_click_mixer_tb.sv
